### rtl/lu8d_pkg.sv
// ----------------------------------------------------------------------------
// lu8d_pkg
// shared widths, byte masks and lead byte codes of the lenient utf-8 decoder
// ----------------------------------------------------------------------------
package lu8d_pkg;

   localparam int BYTE_W    = 8;
   localparam int CP_W      = 21;
   localparam int LEFT_W    = 2;
   localparam int RSP_DATA_W = ((CP_W + 7) / 8) * 8;

   localparam logic [BYTE_W-1:0] ASCII_LIMIT = 8'h80;
   localparam logic [BYTE_W-1:0] LEAD2_MASK  = 8'h1F;
   localparam logic [BYTE_W-1:0] LEAD3_MASK  = 8'h0F;
   localparam logic [BYTE_W-1:0] LEAD4_MASK  = 8'h07;
   localparam logic [BYTE_W-1:0] CONT_MASK   = 8'h3F;

   // top bits of each byte class
   localparam logic [2:0] LEAD2_CODE = 3'b110;
   localparam logic [3:0] LEAD3_CODE = 4'b1110;
   localparam logic [4:0] LEAD4_CODE = 5'h1E;
   localparam logic [1:0] CONT_CODE  = 2'b10;

   localparam logic [LEFT_W-1:0] LEFT_NONE = 2'd0;
   localparam logic [LEFT_W-1:0] LEFT_ONE  = 2'd1;
   localparam logic [LEFT_W-1:0] LEFT_TWO  = 2'd2;
   localparam logic [LEFT_W-1:0] LEFT_THREE = 2'd3;

   typedef struct packed {
      logic [LEFT_W-1:0] bytes_left;
      logic [CP_W-1:0]   accumulator;
      logic              spoiled;
   } dec_state_type;

endpackage

### rtl/lenient_utf8_decoder_core.sv
// ----------------------------------------------------------------------------
// lenient_utf8_decoder_core
// byte-stream utf-8 decoder giving one result per input byte
// ----------------------------------------------------------------------------
// usage:
//   req channel carries one raw text byte per request in req_tdata, with
//   req_tlast on the final byte of a text. rsp channel returns one result per
//   byte: rsp_tuser high when that byte completes a nonzero codepoint, the
//   codepoint in rsp_tdata (zero otherwise) and rsp_tlast echoing req_tlast.
//   stray lead bytes, spoiled sequences and sequences cut off by the end of
//   text give rsp_tuser low.
// pipeline and throughput:
//   a byte is held in an input register and decoded into the result register,
//   where its result is shown once the result register is free to take it.
//   one byte per cycle is sustained while rsp_tready stays high; the decode
//   state update in front of the result register sets that figure.
// reset and stalls:
//   reset empties both registers and clears the decode state. while rsp_tready
//   is low a waiting result holds and one more request can still be taken into
//   the input register; after that req_tready drops until the result leaves.
// ----------------------------------------------------------------------------
module lenient_utf8_decoder_core (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_tvalid,
   output logic                        req_tready,
   input  logic [lu8d_pkg::BYTE_W-1:0] req_tdata,   // [7:0] in_byte
   input  logic                        req_tlast,   // text_end
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   output logic [lu8d_pkg::RSP_DATA_W-1:0] rsp_tdata, // [20:0] codepoint, rest zero
   output logic                        rsp_tuser,   // cp_valid
   output logic                        rsp_tlast    // end_of_text
);
   import lu8d_pkg::*;

   logic                  in_valid_ff;
   logic [BYTE_W-1:0]     in_byte_ff;
   logic                  in_last_ff;

   dec_state_type         state_ff;
   dec_state_type         state_in;

   logic                  out_valid_ff;
   logic [CP_W-1:0]       out_cp_ff;
   logic                  out_flag_ff;
   logic                  out_last_ff;

   logic                  cp_valid_in;
   logic [CP_W-1:0]       cp_in;
   logic                  advance;

   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;

   // decode of the byte in the input register
   always_comb begin
      state_in    = state_ff;
      cp_valid_in = 1'b0;
      cp_in       = '0;
      if (state_ff.bytes_left == LEFT_NONE) begin
         if (in_byte_ff < ASCII_LIMIT) begin
            if (in_byte_ff != '0) begin
               cp_valid_in = 1'b1;
               cp_in       = CP_W'(in_byte_ff);
            end
         end else if (in_byte_ff[7:5] == LEAD2_CODE) begin
            state_in.accumulator = CP_W'(in_byte_ff & LEAD2_MASK);
            state_in.bytes_left  = LEFT_ONE;
            state_in.spoiled     = 1'b0;
         end else if (in_byte_ff[7:4] == LEAD3_CODE) begin
            state_in.accumulator = CP_W'(in_byte_ff & LEAD3_MASK);
            state_in.bytes_left  = LEFT_TWO;
            state_in.spoiled     = 1'b0;
         end else if (in_byte_ff[7:3] == LEAD4_CODE) begin
            state_in.accumulator = CP_W'(in_byte_ff & LEAD4_MASK);
            state_in.bytes_left  = LEFT_THREE;
            state_in.spoiled     = 1'b0;
         end
      end else begin
         if (!state_ff.spoiled) begin
            if (in_byte_ff[7:6] == CONT_CODE) begin
               state_in.accumulator = {state_ff.accumulator[CP_W-7:0],
                                       in_byte_ff[5:0] & CONT_MASK[5:0]};
            end else begin
               state_in.spoiled     = 1'b1;
               state_in.accumulator = '0;
            end
         end
         state_in.bytes_left = state_ff.bytes_left - LEFT_ONE;
         if (state_in.bytes_left == LEFT_NONE && !state_in.spoiled &&
             state_in.accumulator != '0) begin
            cp_valid_in = 1'b1;
            cp_in       = state_in.accumulator;
         end
      end
      if (in_last_ff) begin
         state_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         state_ff     <= '0;
      end else begin
         if (req_tready) begin
            in_valid_ff <= req_tvalid;
         end
         if (advance) begin
            out_valid_ff <= 1'b1;
            state_ff     <= state_in;
         end else if (rsp_tready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_byte_ff <= req_tdata;
         in_last_ff <= req_tlast;
      end
      if (advance) begin
         out_cp_ff   <= cp_in;
         out_flag_ff <= cp_valid_in;
         out_last_ff <= in_last_ff;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = RSP_DATA_W'(out_cp_ff);
   assign rsp_tuser  = out_flag_ff;
   assign rsp_tlast  = out_last_ff;

endmodule
